[design/bipr_pkg.sv]
// Shared constants, types and helper functions of the isolated pixel removal block.
package bipr_pkg;

  // Geometry and storage.
  localparam int MAX_WIDTH   = 1024;
  localparam int STORE_DEPTH = 2 * MAX_WIDTH + 4;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int DIM_W       = 11;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int PEND_W      = $clog2(MAX_WIDTH + 2);
  localparam int PIX_W       = 8;

  // Filter constants.
  localparam logic [PIX_W-1:0] WHITE     = 8'd255;
  localparam logic [3:0]       MIN_WHITE = 4'd3;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIM_W;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1024);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1024);
  localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(3);
  localparam logic [DIM_W-1:0] MAX_DIM_W    = DIM_W'(MAX_WIDTH);

  // Window reload sequencer, one-hot.
  typedef enum logic [4:0] {
    ST_RUN = 5'b00001,
    ST_R0  = 5'b00010,
    ST_R1  = 5'b00100,
    ST_R2  = 5'b01000,
    ST_R3  = 5'b10000
  } refill_e;

  // Pixel store access for one cycle.
  typedef struct packed {
    logic             a_we;
    logic [PTR_W-1:0] a_waddr;
    logic [PIX_W-1:0] a_wdata;
    logic             rd_en;
    logic [PTR_W-1:0] a0_addr;
    logic [PTR_W-1:0] a1_addr;
    logic [PTR_W-1:0] b_addr;
    logic             b_we;
    logic [PTR_W-1:0] b_waddr;
  } store_ctrl_t;

  // Window and filter control.
  typedef struct packed {
    logic             shift;
    logic             load_l;
    logic             load_c;
    logic             load_ml;
    logic             interior;
    logic             flush;
    logic             bypass;
    logic [PIX_W-1:0] byp_pixel;
  } filt_ctrl_t;

  // Modular add on store pointers; both operands are below STORE_DEPTH.
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                               input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, ptr} + {1'b0, off};
    if (sum >= (PTR_W + 1)'(STORE_DEPTH)) begin
      sum = sum - (PTR_W + 1)'(STORE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

[design/bipr_if.sv]
// Request channel interfaces for the pixel input and the filtered pixel output.
interface pix_in_if;
  import bipr_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink (input valid, input mode, input pixel_in, output ready);
endinterface

interface pix_out_if;
  import bipr_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

[design/bipr_store.sv]
// Raw pixel store with two read ports and filtered pixel store with one read port.
module bipr_store (
  input  logic                           clk_i,
  input  bipr_pkg::store_ctrl_t          ctrl_i,
  input  logic [bipr_pkg::PIX_W-1:0]     b_wdata_i,
  output logic [bipr_pkg::PIX_W-1:0]     a0_data_o,
  output logic [bipr_pkg::PIX_W-1:0]     a1_data_o,
  output logic [bipr_pkg::PIX_W-1:0]     b_data_o
);
  import bipr_pkg::*;

  logic [PIX_W-1:0] raw_mem [STORE_DEPTH];
  logic [PIX_W-1:0] filt_mem [STORE_DEPTH];

  // Raw pixels as they arrive.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.a_we) begin
      raw_mem[ctrl_i.a_waddr] <= ctrl_i.a_wdata;
    end
    if (ctrl_i.rd_en) begin
      a0_data_o <= raw_mem[ctrl_i.a0_addr];
      a1_data_o <= raw_mem[ctrl_i.a1_addr];
    end
  end

  // Pixels as they leave the block, filtered where the filter applied.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.b_we) begin
      filt_mem[ctrl_i.b_waddr] <= b_wdata_i;
    end
    if (ctrl_i.rd_en) begin
      b_data_o <= filt_mem[ctrl_i.b_addr];
    end
  end

endmodule

[design/bipr_filter.sv]
// 3x3 window registers, white neighbor count and the output pixel value.
module bipr_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bipr_pkg::filt_ctrl_t       ctrl_i,
  input  logic [bipr_pkg::PIX_W-1:0] a0_data_i,
  input  logic [bipr_pkg::PIX_W-1:0] a1_data_i,
  input  logic [bipr_pkg::PIX_W-1:0] b_data_i,
  output logic [bipr_pkg::PIX_W-1:0] value_o
);
  import bipr_pkg::*;

  // Left and center columns; the right column comes from the store read.
  logic [PIX_W-1:0] top_l_q, top_c_q, mid_l_q, mid_c_q, bot_l_q, bot_c_q;
  logic [PIX_W-1:0] bot_r;
  logic [3:0]       white_cnt;
  logic [PIX_W-1:0] filtered;

  assign bot_r = ctrl_i.bypass ? ctrl_i.byp_pixel : a1_data_i;

  // Count the neighbors that are white and select the output pixel value.
  always_comb begin
    white_cnt = 4'((top_l_q == WHITE)) + 4'((top_c_q == WHITE)) + 4'((b_data_i == WHITE))
              + 4'((mid_l_q == WHITE)) + 4'((a0_data_i == WHITE))
              + 4'((bot_l_q == WHITE)) + 4'((bot_c_q == WHITE)) + 4'((bot_r == WHITE));
    filtered = (ctrl_i.interior && (white_cnt < MIN_WHITE)) ? '0 : mid_c_q;
    value_o  = ctrl_i.flush ? a0_data_i : filtered;
  end

  // Window shift on each filtered pixel, or reload column by column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_l_q <= '0;
      top_c_q <= '0;
      mid_l_q <= '0;
      mid_c_q <= '0;
      bot_l_q <= '0;
      bot_c_q <= '0;
    end else if (ctrl_i.shift) begin
      top_l_q <= top_c_q;
      top_c_q <= b_data_i;
      mid_l_q <= value_o;
      mid_c_q <= a0_data_i;
      bot_l_q <= bot_c_q;
      bot_c_q <= bot_r;
    end else if (ctrl_i.load_l) begin
      top_l_q <= b_data_i;
      bot_l_q <= a0_data_i;
    end else if (ctrl_i.load_c) begin
      top_c_q <= b_data_i;
      mid_c_q <= a0_data_i;
      bot_c_q <= a1_data_i;
    end else if (ctrl_i.load_ml) begin
      mid_l_q <= b_data_i;
    end
  end

endmodule

[design/bipr_seq.sv]
// Configuration, pointers, frame position, window reload sequencer and the work stage.
module bipr_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bipr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bipr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pix_in_if.sink                          pix_in_i,
  input  logic                            out_free_i,
  output bipr_pkg::store_ctrl_t           store_o,
  output bipr_pkg::filt_ctrl_t            filt_o,
  output logic                            advance_o,
  output logic                            last_o
);
  import bipr_pkg::*;

  logic [DIM_W-1:0]  width_q, height_q;
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [PTR_W-1:0]  w_ptr;
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [DIM_W-1:0]  row_q, row_d;
  logic [COL_W:0]    col_inc;
  logic [DIM_W:0]    row_inc;
  refill_e           state_q, state_d;
  logic              win_valid_q, win_valid_d;
  logic              need_refill, in_ready, accept, is_pixel, emit;
  logic              interior, last;
  logic [PTR_W-1:0]  off_a0, off_a1, off_b;
  logic [PTR_W-1:0]  a0_addr, a1_addr, b_addr;

  // Work stage registers.
  logic              s_valid_q, s_flush_q, s_interior_q, s_bypass_q, s_last_q;
  logic [PIX_W-1:0]  s_pixel_q;
  logic [PTR_W-1:0]  s_rd_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped geometry.
  always_comb begin
    w_eff = width_q;
    if (width_q < MIN_DIM) w_eff = MIN_DIM;
    if (width_q > MAX_DIM_W) w_eff = MAX_DIM_W;
    h_eff = (height_q < MIN_DIM) ? MIN_DIM : height_q;
    w_ptr = PTR_W'(w_eff);
  end

  // Handshake and item classification.
  assign need_refill = !win_valid_q && ({1'b0, pend_q} >= ({1'b0, w_eff} + 12'd1));
  assign in_ready    = (state_q == ST_RUN) && !need_refill && (!s_valid_q || out_free_i);
  assign pix_in_i.ready = in_ready;
  assign accept      = pix_in_i.valid && in_ready;
  assign is_pixel    = !pix_in_i.mode;
  assign emit        = is_pixel ? ({1'b0, pend_q} >= ({1'b0, w_eff} + 12'd1))
                                : (pend_q != '0);
  assign advance_o   = s_valid_q && out_free_i;

  // Position of the oldest pending pixel within the frame.
  always_comb begin
    interior = (row_q != '0) && (({1'b0, row_q} + 12'd1) < {1'b0, h_eff})
            && (col_q != '0) && (({1'b0, col_q} + 11'd1) < w_eff);
    last     = (row_q == (h_eff - DIM_W'(1))) && (({1'b0, col_q} + 11'd1) == w_eff);
    col_inc  = {1'b0, col_q} + (COL_W + 1)'(1);
    row_inc  = {1'b0, row_q} + (DIM_W + 1)'(1);
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[DIM_W-1:0];
    end else begin
      col_d = col_inc[COL_W-1:0];
      row_d = (row_q >= h_eff) ? '0 : row_q;
    end
  end

  // Store read offsets, relative to the oldest pending pixel.
  always_comb begin
    off_a0 = '0;
    off_a1 = '0;
    off_b  = '0;
    unique case (state_q)
      ST_RUN: begin
        off_a0 = is_pixel ? PTR_W'(1) : '0;
        off_a1 = w_ptr + PTR_W'(1);
        off_b  = PTR_W'(STORE_DEPTH + 1) - w_ptr;
      end
      ST_R0: begin
        off_a0 = w_ptr - PTR_W'(1);
        off_b  = PTR_W'(STORE_DEPTH - 1) - w_ptr;
      end
      ST_R1: begin
        off_a1 = w_ptr;
        off_b  = PTR_W'(STORE_DEPTH) - w_ptr;
      end
      ST_R2: begin
        off_b  = PTR_W'(STORE_DEPTH - 1);
      end
      ST_R3: ;
      default: ;
    endcase
    a0_addr = ptr_add(rd_q, off_a0);
    a1_addr = ptr_add(rd_q, off_a1);
    b_addr  = ptr_add(rd_q, off_b);
  end

  // Store access.
  always_comb begin
    store_o.a_we    = accept && is_pixel;
    store_o.a_waddr = wr_q;
    store_o.a_wdata = pix_in_i.pixel_in;
    store_o.rd_en   = accept || (state_q == ST_R0) || (state_q == ST_R1)
                   || (state_q == ST_R2);
    store_o.a0_addr = a0_addr;
    store_o.a1_addr = a1_addr;
    store_o.b_addr  = b_addr;
    store_o.b_we    = advance_o;
    store_o.b_waddr = s_rd_q;
  end

  // Window reload sequencer.
  always_comb begin
    state_d     = state_q;
    win_valid_d = win_valid_q;
    unique case (state_q)
      ST_RUN: if (need_refill && !s_valid_q) state_d = ST_R0;
      ST_R0:  state_d = ST_R1;
      ST_R1:  state_d = ST_R2;
      ST_R2:  state_d = ST_R3;
      ST_R3: begin
        state_d     = ST_RUN;
        win_valid_d = 1'b1;
      end
      default: state_d = ST_RUN;
    endcase
    if (accept && !is_pixel && emit) win_valid_d = 1'b0;
    if (cfg_we_i) win_valid_d = 1'b0;
  end

  // Pending count follows pixels in and pixels out.
  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      if (is_pixel && !emit) pend_d = pend_q + PEND_W'(1);
      else if (!is_pixel && emit) pend_d = pend_q - PEND_W'(1);
    end
  end

  // Pointers, position and sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q        <= '0;
      rd_q        <= '0;
      pend_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      state_q     <= ST_RUN;
      win_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_valid_q <= win_valid_d;
      pend_q      <= pend_d;
      if (accept && is_pixel) wr_q <= ptr_add(wr_q, PTR_W'(1));
      if (accept && emit) begin
        rd_q  <= ptr_add(rd_q, PTR_W'(1));
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // Work stage: one emitted pixel at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (accept) begin
      s_valid_q <= emit;
    end else if (advance_o) begin
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_flush_q    <= !is_pixel;
      s_interior_q <= interior;
      s_bypass_q   <= is_pixel && (a1_addr == wr_q);
      s_last_q     <= last;
      s_pixel_q    <= pix_in_i.pixel_in;
      s_rd_q       <= rd_q;
    end
  end

  // Filter control.
  always_comb begin
    filt_o.shift     = advance_o && !s_flush_q;
    filt_o.load_l    = (state_q == ST_R1);
    filt_o.load_c    = (state_q == ST_R2);
    filt_o.load_ml   = (state_q == ST_R3);
    filt_o.interior  = s_interior_q;
    filt_o.flush     = s_flush_q;
    filt_o.bypass    = s_bypass_q;
    filt_o.byp_pixel = s_pixel_q;
  end

  assign last_o = s_last_q;

  // The oldest pending pixel sits exactly the pending count behind the write pointer.
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_add(rd_q, PTR_W'(pend_q)) == wr_q)
    else $error("read and write pointers disagree with the pending count");

  // A filtered pixel only leaves with a loaded window.
  a_emit_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_pixel && emit) |-> win_valid_q)
    else $error("pixel filtered with a stale window");

  // A stalled work stage keeps its pixel and its store address.
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_q && !out_free_i) |=> (s_valid_q && $stable(s_rd_q)))
    else $error("work stage lost a pixel under stall");

  // A reload never overlaps a pixel still in the work stage.
  a_refill_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> !s_valid_q)
    else $error("window reload while the work stage is busy");

  // Pending pixels never exceed one row and a pixel.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pend_q} <= (PEND_W + 1)'(MAX_WIDTH + 1))
    else $error("pending count out of range");

endmodule

[design/binary_isolated_pixel_removal.sv]
// Top level of the 3x3 isolated pixel removal filter on a raster pixel stream.
//
// Pixels of a frame enter on pix_in_i in raster order, one request each with
// mode 0; a request with mode 1 drains one pending pixel without filtering.
// A pixel leaves on pix_out_o once the pixel one row and one place after it
// has arrived, i.e. width+1 pixel requests later, with frame_last set on the
// bottom right pixel of the frame. Interior pixels with fewer than three white
// neighbors become zero; border pixels pass unchanged.
// One request is taken per cycle while no reload is due or running and the
// work stage is empty or can pass its pixel on. A result passes the store
// reads and the work stage, then the neighbor count into the output register.
// The window of neighbors is reloaded from the two pixel stores after reset,
// after a drain request that drains a pixel and after a configuration write,
// once a row and one more pixel are pending and the work stage is empty. No
// request is taken at its start or in states R0 to R3, which use the single
// read port of the filtered pixel store. Reset empties the block; the stores
// need no clearing. When the receiver stalls, the output register holds its
// result and the block keeps taking requests until its work stage is full.
// Configuration registers: index 0 image width, index 1 image height.
module binary_isolated_pixel_removal (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bipr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bipr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pix_in_if.sink                          pix_in_i,
  pix_out_if.source                       pix_out_o
);
  import bipr_pkg::*;

  store_ctrl_t      store_ctrl;
  filt_ctrl_t       filt_ctrl;
  logic             advance, stage_last, out_free;
  logic [PIX_W-1:0] a0_data, a1_data, b_data, value;

  logic             o_valid_q;
  logic [PIX_W-1:0] o_pixel_q;
  logic             o_last_q;

  assign out_free = !o_valid_q || pix_out_o.ready;

  bipr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_in_i   (pix_in_i),
    .out_free_i (out_free),
    .store_o    (store_ctrl),
    .filt_o     (filt_ctrl),
    .advance_o  (advance),
    .last_o     (stage_last)
  );

  bipr_store u_store (
    .clk_i     (clk_i),
    .ctrl_i    (store_ctrl),
    .b_wdata_i (value),
    .a0_data_o (a0_data),
    .a1_data_o (a1_data),
    .b_data_o  (b_data)
  );

  bipr_filter u_filter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (filt_ctrl),
    .a0_data_i (a0_data),
    .a1_data_i (a1_data),
    .b_data_i  (b_data),
    .value_o   (value)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (advance) begin
      o_valid_q <= 1'b1;
    end else if (pix_out_o.ready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      o_pixel_q <= value;
      o_last_q  <= stage_last;
    end
  end

  assign pix_out_o.valid      = o_valid_q;
  assign pix_out_o.pixel_out  = o_pixel_q;
  assign pix_out_o.frame_last = o_last_q;

endmodule
